@@ rtl/mse_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the share engine.
`timescale 1ns / 1ps

package mse_pkg;

    localparam int MAX_ORDER_DEF = 7;
    localparam int WORD_BITS_DEF = 64;

    localparam int REQ_W      = 3;
    localparam int IDX_W      = 3;
    localparam int STS_W      = 2;
    localparam int ORDER_W    = 3;
    localparam int SEL_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int DATA_W     = 64;

    localparam logic [REQ_W-1:0] REQ_LOAD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REFRESH = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNMASK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd4;

    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_BAD_INDEX = 2'd1;
    localparam logic [STS_W-1:0] STS_BAD_REQ   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WSIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 2'd2;

    localparam logic [SEL_W-1:0] WSIZE_8  = 2'd0;
    localparam logic [SEL_W-1:0] WSIZE_16 = 2'd1;
    localparam logic [SEL_W-1:0] WSIZE_32 = 2'd2;
    localparam logic [SEL_W-1:0] WSIZE_64 = 2'd3;

    // What to do with share data when it returns from the store in the next cycle
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_ACCUM    = 3'd1,
        OP_REF_BASE = 3'd2,
        OP_REF_IDX  = 3'd3,
        OP_CAPTURE  = 3'd4
    } t_rd_op;

    typedef struct packed {
        logic              capture;
        logic              acc_clr;
        logic              wr_load;
        logic              wr_share;
        logic [IDX_W-1:0]  rd_idx;
        t_rd_op            rd_op;
        logic              out_load;
        logic [STS_W-1:0]  out_status;
    } t_ctl_cmd;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic               ref_idx_bad;
        logic               acc_idx_bad;
        logic [IDX_W-1:0]   idx;
        logic [ORDER_W-1:0] order;
        logic               out_free;
    } t_dp_sts;

endpackage

@@ rtl/masked_share_engine.sv @@
// Top level of the masked share engine: controller plus datapath.
// Load, write share and errored requests decode then finish; read share adds a drain, refresh
// a second access and a drain, unmask walks shares 1..order (clamped to 1..7), one share
// a cycle, then a drain. One request in flight; the next is taken the cycle after its result
// is loaded. A waiting result does not block taking a new request.
// Reset (synchronous, active low) zeroes all shares and sets Boolean, 64-bit words, order 1.
`timescale 1ns / 1ps

module masked_share_engine
    import mse_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [DATA_W-1:0]     i_data_word,
    input  logic [DATA_W-1:0]     i_random_word,
    input  logic [IDX_W-1:0]      i_share_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [DATA_W-1:0]     o_result_word,
    output logic [STS_W-1:0]      o_status
);

    t_ctl_cmd cmd;
    t_dp_sts  sts;

    mse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mse_datapath #(
        .MAX_ORDER (MAX_ORDER),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_data_word   (i_data_word),
        .i_random_word (i_random_word),
        .i_share_index (i_share_index),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_result_word (o_result_word),
        .o_status      (o_status)
    );

endmodule

@@ rtl/mse_datapath.sv @@
// Share engine datapath: config registers, request capture, share store, accumulator, result register.
`timescale 1ns / 1ps

module mse_datapath
    import mse_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [DATA_W-1:0]     i_data_word,
    input  logic [DATA_W-1:0]     i_random_word,
    input  logic [IDX_W-1:0]      i_share_index,
    input  logic                  i_out_stall,
    input  t_ctl_cmd              i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    output logic [DATA_W-1:0]     o_result_word,
    output logic [STS_W-1:0]      o_status
);

    localparam int ORDER_MAXV = (1 << ORDER_W) - 1;
    localparam int ORDER_CAP  = (MAX_ORDER < ORDER_MAXV) ? MAX_ORDER : ORDER_MAXV;
    localparam int DEPTH      = ORDER_CAP + 1;
    localparam int AW         = $clog2(DEPTH);
    localparam int SH8        = (WORD_BITS > 8)  ? WORD_BITS - 8  : 0;
    localparam int SH16       = (WORD_BITS > 16) ? WORD_BITS - 16 : 0;
    localparam int SH32       = (WORD_BITS > 32) ? WORD_BITS - 32 : 0;
    localparam int SH64       = (WORD_BITS > 64) ? WORD_BITS - 64 : 0;
    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    logic                 r_domain;
    logic [SEL_W-1:0]     r_wsize;
    logic [ORDER_W-1:0]   r_order;

    logic [REQ_W-1:0]     r_req;
    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] r_rnd;
    logic [IDX_W-1:0]     r_idx;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]     r_vld;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;
    t_rd_op               r_op;
    logic [AW-1:0]        r_wb_addr;
    logic [WORD_BITS-1:0] r_acc;

    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_result;
    logic [STS_W-1:0]     r_out_status;

    logic [WORD_BITS-1:0] mask;
    logic [ORDER_W-1:0]   order_eff;
    logic [WORD_BITS-1:0] rdv;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    always_comb begin
        case (r_wsize)
            WSIZE_8:  mask = ONES >> SH8;
            WSIZE_16: mask = ONES >> SH16;
            WSIZE_32: mask = ONES >> SH32;
            WSIZE_64: mask = ONES >> SH64;
            default:  mask = ONES;
        endcase
    end

    // Order zero acts as one; clamp to what the store holds
    always_comb begin
        if (r_order == '0) begin
            order_eff = ORDER_W'(1);
        end else if (r_order > ORDER_W'(ORDER_CAP)) begin
            order_eff = ORDER_W'(ORDER_CAP);
        end else begin
            order_eff = r_order;
        end
    end

    assign rdv     = (r_rd_vld ? r_rd_data : '0) & mask;
    assign rd_addr = AW'(i_cmd.rd_idx);

    // Write-back of a refresh half, or a direct write for load / write share
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_data;
        case (r_op)
            OP_REF_BASE: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = (r_domain ? (rdv - r_rnd) : (rdv ^ r_rnd)) & mask;
            end
            OP_REF_IDX: begin
                wr_en   = 1'b1;
                wr_addr = r_wb_addr;
                wr_data = (r_domain ? (rdv + r_rnd) : (rdv ^ r_rnd)) & mask;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
        if (i_cmd.wr_load) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = r_data;
        end else if (i_cmd.wr_share) begin
            wr_en   = 1'b1;
            wr_addr = AW'(r_idx);
            wr_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_domain <= 1'b0;
            r_wsize  <= WSIZE_64;
            r_order  <= ORDER_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DOMAIN: r_domain <= i_cfg_data[0];
                CFG_WSIZE:  r_wsize  <= i_cfg_data[SEL_W-1:0];
                CFG_ORDER:  r_order  <= i_cfg_data[ORDER_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_type;
            r_data <= i_data_word[WORD_BITS-1:0] & mask;
            r_rnd  <= i_random_word[WORD_BITS-1:0] & mask;
            r_idx  <= i_share_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_op != OP_NONE) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
            r_wb_addr <= rd_addr;
        end
    end

    // Load drops every share but share zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_op  <= OP_NONE;
        end else begin
            if (i_cmd.wr_load) begin
                r_vld <= DEPTH'(1);
            end else if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_op <= i_cmd.rd_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_op == OP_ACCUM) begin
            r_acc <= (r_domain ? (r_acc + rdv) : (r_acc ^ rdv)) & mask;
        end else if (r_op == OP_CAPTURE) begin
            r_acc <= rdv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_result <= r_acc;
            r_out_status <= i_cmd.out_status;
        end
    end

    assign o_sts.req         = r_req;
    assign o_sts.ref_idx_bad = (r_idx == '0) || (r_idx > order_eff);
    assign o_sts.acc_idx_bad = (r_idx > order_eff);
    assign o_sts.idx         = r_idx;
    assign o_sts.order       = order_eff;
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_result_word = DATA_W'(r_out_result);
    assign o_status      = r_out_status;

endmodule

@@ rtl/mse_ctrl.sv @@
// Share engine controller: sequences one request at a time over the share store.
`timescale 1ns / 1ps

module mse_ctrl
    import mse_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_WALK   = 6'b000100,
        S_REF1   = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   n_cnt;
    logic [STS_W-1:0]   r_status;
    logic [STS_W-1:0]   n_status;

    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        n_status         = r_status;
        o_cmd            = '0;
        o_cmd.rd_op      = OP_NONE;
        o_cmd.out_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.acc_clr = 1'b1;
                n_status      = STS_OK;
                n_state       = S_DONE;
                case (i_sts.req)
                    REQ_LOAD: begin
                        o_cmd.wr_load = 1'b1;
                    end
                    REQ_REFRESH: begin
                        if (i_sts.ref_idx_bad) begin
                            n_status = STS_BAD_INDEX;
                        end else begin
                            o_cmd.rd_idx = '0;
                            o_cmd.rd_op  = OP_REF_BASE;
                            n_state      = S_REF1;
                        end
                    end
                    REQ_UNMASK: begin
                        o_cmd.rd_idx = '0;
                        o_cmd.rd_op  = OP_ACCUM;
                        n_cnt        = IDX_W'(1);
                        n_state      = S_WALK;
                    end
                    REQ_READ: begin
                        if (i_sts.acc_idx_bad) begin
                            n_status = STS_BAD_INDEX;
                        end else begin
                            o_cmd.rd_idx = i_sts.idx;
                            o_cmd.rd_op  = OP_CAPTURE;
                            n_state      = S_DRAIN;
                        end
                    end
                    REQ_WRITE: begin
                        if (i_sts.acc_idx_bad) begin
                            n_status = STS_BAD_INDEX;
                        end else begin
                            o_cmd.wr_share = 1'b1;
                        end
                    end
                    default: begin
                        n_status = STS_BAD_REQ;
                    end
                endcase
            end
            S_WALK: begin
                // One share per cycle; the last one lands during drain
                o_cmd.rd_idx = r_cnt;
                o_cmd.rd_op  = OP_ACCUM;
                if (r_cnt >= i_sts.order) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            S_REF1: begin
                o_cmd.rd_idx = i_sts.idx;
                o_cmd.rd_op  = OP_REF_IDX;
                n_state      = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold until the result register can take the answer
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_status <= STS_OK;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_status <= n_status;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_capture_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == S_DECODE)
        else $error("accepted request did not enter decode");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_cnt <= i_sts.order)
        else $error("unmask walk ran past the share count");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_sts.out_free) |=> r_state == S_DONE)
        else $error("result dropped while output register busy");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE && !o_in_stall))
        else $error("controller not idle after delivering a result");

endmodule
